>>> hdl/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
package bbc_pkg;

	localparam int KIND_W   = 4;
	localparam int STATUS_W = 3;
	localparam int DEPTH_W  = 6;

	typedef logic [KIND_W-1:0] kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_UNOPENED = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_UNCLOSED = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_NOTHING  = 3'd5
	} status_t;

	// Write port request into the opener stack memory
	typedef struct packed {
		logic  en;
		kind_t data;
	} bbc_wr_t;

endpackage

>>> hdl/bbc_stack_mem.sv
// Opener stack storage: one write port, one registered read port.
module bbc_stack_mem
	import bbc_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  bbc_wr_t       wr,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] raddr,
	output kind_t         rdata
);

	kind_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/bracket_balance_checker_unit.sv
// Bracket balance checker top level: sequencer around the opener stack memory.
//
// Bracket tokens enter on the in channel and each gives one result on the out
// channel; a flush gives one per open entry, or one on an empty stack. A token
// is accepted in a cycle in which the stack top is read from the synchronous
// memory; in S_EXEC, the decide state, it is pushed or popped and the output
// register is loaded. A flush drains the stack one open entry at a time
// (memory read, then output). The stack holds STACK_DEPTH entries; an opener
// on a full stack reports overflow and is dropped. No clearing pass is needed
// after reset: only entries below the stack count are ever used.
module bracket_balance_checker_unit
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic                is_closer,
	input  logic [KIND_W-1:0]   bracket_kind,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [KIND_W-1:0]   found_kind,
	output logic [KIND_W-1:0]   expected_kind,
	output logic [DEPTH_W-1:0]  open_depth,
	output logic                last
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FLUSH,
		S_FLUSH_RD
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            is_closer_q;
	kind_t           kind_q;

	logic            out_valid_q;
	status_t         status_q;
	kind_t           found_q;
	kind_t           expected_q;
	logic [DEPTH_W-1:0] depth_q;
	logic            last_q;

	logic            out_free;
	logic            out_load;
	logic            in_take;
	logic [CW-1:0]   count_dec;
	logic [AW-1:0]   raddr;
	kind_t           top;
	bbc_wr_t         wr;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == S_EXEC) || (state_q == S_FLUSH && out_free);
	assign in_stall  = !(state_q == S_IDLE && out_free);
	assign in_take   = in_valid && !in_stall;
	assign count_dec = count_q - ONE;
	// Always peeking at the current top; the read data is registered, so it lags the count
	assign raddr     = count_dec[AW-1:0];

	assign wr.en   = (state_q == S_EXEC) && !is_closer_q && (count_q != FULL);
	assign wr.data = kind_q;

	bbc_stack_mem #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.wr   (wr),
		.waddr(count_q[AW-1:0]),
		.raddr(raddr),
		.rdata(top)
	);

	always_ff @(posedge clk) begin
		if (in_take) begin
			is_closer_q <= is_closer;
			kind_q      <= bracket_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			found_q     <= '0;
			expected_q  <= '0;
			depth_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= mode ? S_FLUSH : S_EXEC;
					end
				end
				S_EXEC: begin
					// output register is free here: it was free at accept
					out_valid_q <= 1'b1;
					found_q     <= kind_q;
					last_q      <= 1'b1;
					state_q     <= S_IDLE;
					if (is_closer_q) begin
						if (count_q == '0) begin
							status_q   <= ST_UNOPENED;
							expected_q <= '0;
							depth_q    <= '0;
						end else if (top != kind_q) begin
							status_q   <= ST_MISMATCH;
							expected_q <= top;
							depth_q    <= DEPTH_W'(count_q);
						end else begin
							status_q   <= ST_OK;
							expected_q <= '0;
							count_q    <= count_dec;
							depth_q    <= DEPTH_W'(count_dec);
						end
					end else if (count_q == FULL) begin
						status_q   <= ST_OVERFLOW;
						expected_q <= '0;
						depth_q    <= DEPTH_W'(count_q);
					end else begin
						status_q   <= ST_OK;
						expected_q <= '0;
						count_q    <= count_q + ONE;
						depth_q    <= DEPTH_W'(count_q + ONE);
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						expected_q  <= '0;
						if (count_q == '0) begin
							status_q <= ST_NOTHING;
							found_q  <= '0;
							depth_q  <= '0;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							status_q <= ST_UNCLOSED;
							found_q  <= top;
							depth_q  <= DEPTH_W'(count_dec);
							last_q   <= (count_q == ONE);
							count_q  <= count_dec;
							state_q  <= (count_q == ONE) ? S_IDLE : S_FLUSH_RD;
						end
					end
				end
				S_FLUSH_RD: begin
					// wait for the read of the new top
					state_q <= S_FLUSH;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign found_kind    = found_q;
	assign expected_kind = expected_q;
	assign open_depth    = depth_q;
	assign last          = last_q;

endmodule

>>> hdl/bbc_checker.sv
// Port-level checks for the bracket balance checker, bound to the top level.
module bbc_checker
	import bbc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [KIND_W-1:0]   found_kind,
	input logic [KIND_W-1:0]   expected_kind,
	input logic [DEPTH_W-1:0]  open_depth,
	input logic                last
);

	// one transaction at a time: no input is taken in the cycle after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on two consecutive cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_kind)
			&& $stable(open_depth) && $stable(last))
		else $error("stalled result changed");

	a_unopened_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNOPENED |-> open_depth == '0 && last)
		else $error("unopened closer with nonzero depth");

	a_expected_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_MISMATCH |-> expected_kind == '0)
		else $error("expected kind set outside a mismatch");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNCLOSED |-> (last == (open_depth == '0)))
		else $error("drain last flag does not match empty stack");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.found_kind   (found_kind),
	.expected_kind(expected_kind),
	.open_depth   (open_depth),
	.last         (last)
);

>>> bench/bracket_nesting_monitor.sv
// Monitor for the bracket balance checker: tracks the opener stack, predicts and compares results.
module bracket_nesting_monitor
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                mode,
	input  logic                is_closer,
	input  logic [KIND_W-1:0]   bracket_kind,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [STATUS_W-1:0] status,
	input  logic [KIND_W-1:0]   found_kind,
	input  logic [KIND_W-1:0]   expected_kind,
	input  logic [DEPTH_W-1:0]  open_depth,
	input  logic                last,
	output int                  fail_count,
	output int                  pending,
	output int                  results_seen,
	output logic [5:0]          status_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t              status;
		kind_t                found;
		kind_t                expected;
		logic [DEPTH_W-1:0]   depth;
		logic                 last;
	} report_t;

	report_t awaited_reports[$];
	kind_t   open_kinds[STACK_DEPTH];
	int      open_count;
	int      fails;
	int      seen;
	logic [5:0] codes;

	function automatic void queue_report(status_t s, kind_t f, kind_t e, int d, logic l);
		report_t r;
		r.status   = s;
		r.found    = f;
		r.expected = e;
		r.depth    = DEPTH_W'(d);
		r.last     = l;
		awaited_reports.push_back(r);
	endfunction

	// One accepted transaction: update the stack and queue the results it causes.
	function automatic void advance_nesting(logic m, logic c, kind_t k);
		kind_t top;
		if (m) begin
			if (open_count == 0)
				queue_report(ST_NOTHING, '0, '0, 0, 1'b1);
			else
				while (open_count > 0) begin
					open_count--;
					queue_report(ST_UNCLOSED, open_kinds[open_count], '0, open_count,
						open_count == 0);
				end
		end else if (c) begin
			if (open_count == 0) begin
				queue_report(ST_UNOPENED, k, '0, 0, 1'b1);
			end else begin
				top = open_kinds[open_count-1];
				if (top != k) begin
					queue_report(ST_MISMATCH, k, top, open_count, 1'b1);
				end else begin
					open_count--;
					queue_report(ST_OK, k, '0, open_count, 1'b1);
				end
			end
		end else if (open_count >= STACK_DEPTH) begin
			// full stack: push is dropped
			queue_report(ST_OVERFLOW, k, '0, open_count, 1'b1);
		end else begin
			open_kinds[open_count] = k;
			open_count++;
			queue_report(ST_OK, k, '0, open_count, 1'b1);
		end
	endfunction

	function automatic int field_differs(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		report_t want;
		int      errs;
		if (!arst_n) begin
			awaited_reports.delete();
			open_count = 0;
			fails      = 0;
			seen       = 0;
			codes      = '0;
			fail_count   <= 0;
			pending      <= 0;
			results_seen <= 0;
			status_seen  <= '0;
		end else begin
			// compare first: a result can never leave in its own accept cycle
			if (out_valid && !out_stall) begin
				seen++;
				if (status < 6)
					codes[status] = 1'b1;
				if (awaited_reports.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status=%0d found=%0d expected_kind=%0d depth=%0d last=%0b",
						$time, status, found_kind, expected_kind, open_depth, last);
					fails++;
				end else begin
					want = awaited_reports.pop_front();
					errs = field_differs("status", 8'(want.status), 8'(status))
						+ field_differs("found_kind", 8'(want.found), 8'(found_kind))
						+ field_differs("expected_kind", 8'(want.expected), 8'(expected_kind))
						+ field_differs("open_depth", 8'(want.depth), 8'(open_depth))
						+ field_differs("last", 8'(want.last), 8'(last));
					if (errs != 0)
						fails++;
				end
			end
			if (in_valid && !in_stall)
				advance_nesting(mode, is_closer, bracket_kind);
			fail_count   <= fails;
			pending      <= awaited_reports.size();
			results_seen <= seen;
			status_seen  <= codes;
		end
	end

endmodule

>>> bench/bracket_balance_checker_unit_tb.sv
// Testbench top for the bracket balance checker: clock, reset, stimulus, verdict.
module bracket_balance_checker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bbc_pkg::*;

	localparam int STACK_DEPTH  = 32;
	localparam int ITEMS        = 360;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int PAUSE_AT     = 260;
	localparam int IDLE_LIMIT   = 3000;
	localparam int DRAIN_CYCLES = 40;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                mode         = 1'b0;
	logic                is_closer    = 1'b0;
	logic [KIND_W-1:0]   bracket_kind = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KIND_W-1:0]   found_kind;
	logic [KIND_W-1:0]   expected_kind;
	logic [DEPTH_W-1:0]  open_depth;
	logic                last;

	int         fail_count;
	int         pending;
	int         results_seen;
	logic [5:0] status_seen;

	int    sent       = 0;
	int    fills      = 0;
	int    burst_left = 0;
	kind_t gen_open[$];

	bracket_balance_checker_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (.*);

	bracket_nesting_monitor #(.STACK_DEPTH(STACK_DEPTH)) monitor (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly the named kinds, now and then the spare codes
	function automatic kind_t pick_kind();
		if ($urandom_range(0, 7) == 0)
			return kind_t'($urandom_range(10, 15));
		return kind_t'($urandom_range(0, 9));
	endfunction

	task automatic offer(logic m, logic c, kind_t k);
		int gap;
		in_valid     <= 1'b1;
		mode         <= m;
		is_closer    <= c;
		bracket_kind <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		// keep a copy of the open kinds so closers can be steered to match
		if (m)
			gen_open.delete();
		else if (!c) begin
			if (gen_open.size() < STACK_DEPTH)
				gen_open.push_back(k);
		end else if (gen_open.size() > 0 && gen_open[$] == k)
			gen_open.delete(gen_open.size() - 1);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(0, 9);
			if (gap < 3)
				gap = 0;
			else if (gap < 9)
				gap = $urandom_range(1, 4);
			else
				gap = $urandom_range(5, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stop offering until every result in flight has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// push to full, overflow one to three times, maybe a mismatched closer, then flush all 32 entries
	task automatic run_fill();
		int extra;
		extra = $urandom_range(1, 3);
		while (gen_open.size() < STACK_DEPTH)
			offer(1'b0, 1'b0, pick_kind());
		repeat (extra) offer(1'b0, 1'b0, pick_kind());
		if ($urandom_range(0, 1))
			offer(1'b0, 1'b1, gen_open[$] ^ kind_t'(1));
		offer(1'b1, 1'($urandom_range(0, 1)), kind_t'($urandom_range(0, 15)));
		fills++;
	endtask

	initial begin : stimulus
		int choice;
		int steps;
		bit paused_once;
		paused_once = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(1'b1, 1'b0, 4'd0);     // flush with nothing open
		offer(1'b0, 1'b1, 4'd9);     // closer with nothing open
		offer(1'b0, 1'b1, 4'd15);
		offer(1'b0, 1'b0, 4'd0);
		offer(1'b0, 1'b0, 4'd15);
		offer(1'b0, 1'b0, 4'd10);
		offer(1'b0, 1'b1, 4'd3);     // wrong kind against top
		offer(1'b0, 1'b1, 4'd10);
		offer(1'b0, 1'b1, 4'd15);
		offer(1'b0, 1'b0, 4'd5);
		offer(1'b0, 1'b0, 4'd5);
		offer(1'b0, 1'b1, 4'd5);
		offer(1'b1, 1'b1, 4'd15);    // flush two open, ignored fields set
		offer(1'b1, 1'b1, 4'd7);
		offer(1'b0, 1'b0, 4'd9);
		offer(1'b0, 1'b1, 4'd9);
		offer(1'b0, 1'b1, 4'd0);
		settle();

		run_fill();
		while (sent < ITEMS) begin
			if (!paused_once && sent >= PAUSE_AT) begin
				settle();
				paused_once = 1'b1;
			end
			choice = $urandom_range(0, 19);
			if (choice < 10) begin
				steps = $urandom_range(2, 16);
				repeat (steps) begin
					if (gen_open.size() == 0
						|| (gen_open.size() < STACK_DEPTH && $urandom_range(0, 1) == 0))
						offer(1'b0, 1'b0, pick_kind());
					else if ($urandom_range(0, 11) == 0)
						offer(1'b0, 1'b1, gen_open[$] ^ kind_t'($urandom_range(1, 15)));
					else
						offer(1'b0, 1'b1, gen_open[$]);
				end
				if ($urandom_range(0, 1))
					while (gen_open.size() > 0)
						offer(1'b0, 1'b1, gen_open[$]);
			end else if (choice < 13) begin
				offer(1'b1, 1'($urandom_range(0, 1)), kind_t'($urandom_range(0, 15)));
			end else if (choice == 13 && fills < 3) begin
				run_fill();
			end else begin
				repeat ($urandom_range(1, 4))
					offer($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
						kind_t'($urandom_range(0, 15)));
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d transactions in, %0d stack fills to overflow, %0d results checked",
			sent, fills, results_seen);
		$display("Status codes returned (one bit per code, ok at right): %06b", status_seen);
		if (fail_count == 0 && pending == 0)
			$display("** bracket_balance_checker_unit: PASSED **");
		else
			$display("** bracket_balance_checker_unit: FAILED **");
		$finish;
	end

	initial begin : receiver
		int hold_left;
		int phase_left;
		int style;
		bit hold_done;
		hold_left  = 0;
		phase_left = 0;
		style      = 0;
		hold_done  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && sent >= HOLD_AT) begin
				// long hold-off so the block backs up into its input
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				if (phase_left == 0) begin
					style      = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= (phase_left % 4 == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("** bracket_balance_checker_unit: FAILED **");
		$finish;
	end

endmodule

>>> files.f
hdl/bbc_pkg.sv
hdl/bbc_stack_mem.sv
hdl/bracket_balance_checker_unit.sv
hdl/bbc_checker.sv
bench/bracket_nesting_monitor.sv
bench/bracket_balance_checker_unit_tb.sv
